// ===== rtl/core/particulate_air_quality_index_unit_defines.svh =====
// Assertion helpers shared by the PM AQI RTL.
`ifndef PARTICULATE_AIR_QUALITY_INDEX_UNIT_DEFINES_SVH
`define PARTICULATE_AIR_QUALITY_INDEX_UNIT_DEFINES_SVH

// Generic clocked check, disabled while reset is asserted.
`define PAQI_CHECK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("paqi check failed");

// Same-cycle implication.
`define PAQI_IMPLY(label, clk, rst_n, ante, cons) \
	`PAQI_CHECK(label, clk, rst_n, (ante) |-> (cons))

`endif

// ===== rtl/core/paqi_pkg.sv =====
// ----------------------------------------------------------------------------
// paqi_pkg
// Types and band tables for the PM2.5 / PM10 air quality index unit.
// ----------------------------------------------------------------------------
package paqi_pkg;

	localparam int BAND_COUNT  = 6;
	localparam int BAND_W      = 3;
	localparam int RECIP_SHIFT = 30;
	localparam logic [8:0] AQI_TOP = 9'd500;

	// One band: concentration limits, index base, index span, concentration
	// span and reciprocal of twice that span (ceil(2^RECIP_SHIFT / (2*den))).
	typedef struct packed {
		logic [11:0] c_lo;
		logic [11:0] c_hi;
		logic [8:0]  i_lo;
		logic [7:0]  span;
		logic [9:0]  den;
		logic [23:0] recip;
	} band_t;

	typedef band_t band_tab_t [BAND_COUNT];

	localparam logic [63:0] ONE_SHL = 64'd1 << RECIP_SHIFT;

	localparam band_tab_t FINE_BANDS = '{
		'{12'd0,    12'd90,   9'd0,   8'd50,  10'd90,  24'((ONE_SHL + 64'd179)  / 64'd180)},
		'{12'd91,   12'd354,  9'd51,  8'd49,  10'd263, 24'((ONE_SHL + 64'd525)  / 64'd526)},
		'{12'd355,  12'd554,  9'd101, 8'd49,  10'd199, 24'((ONE_SHL + 64'd397)  / 64'd398)},
		'{12'd555,  12'd1254, 9'd151, 8'd49,  10'd699, 24'((ONE_SHL + 64'd1397) / 64'd1398)},
		'{12'd1255, 12'd2254, 9'd201, 8'd99,  10'd999, 24'((ONE_SHL + 64'd1997) / 64'd1998)},
		'{12'd2255, 12'd3254, 9'd301, 8'd199, 10'd999, 24'((ONE_SHL + 64'd1997) / 64'd1998)}
	};

	localparam band_tab_t COARSE_BANDS = '{
		'{12'd0,   12'd54,  9'd0,   8'd50,  10'd54,  24'((ONE_SHL + 64'd107) / 64'd108)},
		'{12'd55,  12'd154, 9'd51,  8'd49,  10'd99,  24'((ONE_SHL + 64'd197) / 64'd198)},
		'{12'd155, 12'd254, 9'd101, 8'd49,  10'd99,  24'((ONE_SHL + 64'd197) / 64'd198)},
		'{12'd255, 12'd354, 9'd151, 8'd49,  10'd99,  24'((ONE_SHL + 64'd197) / 64'd198)},
		'{12'd355, 12'd424, 9'd201, 8'd99,  10'd69,  24'((ONE_SHL + 64'd137) / 64'd138)},
		'{12'd425, 12'd604, 9'd301, 8'd199, 10'd179, 24'((ONE_SHL + 64'd357) / 64'd358)}
	};

	typedef struct packed {
		logic signed [15:0] pm25_tenths;
		logic               pm25_present;
		logic signed [15:0] pm10_whole;
		logic               pm10_present;
	} in_t;

	typedef struct packed {
		logic [8:0] aqi;
		logic       aqi_valid;
	} out_t;

	// Per-lane result handed to the merge stage.
	typedef struct packed {
		logic       vld;
		logic       present;
		logic [8:0] sub;
	} lane_res_t;

endpackage

// ===== rtl/core/paqi_lane.sv =====
// ----------------------------------------------------------------------------
// paqi_lane
// Sub-index pipeline for one pollutant: band select, interpolation, rounding.
// ----------------------------------------------------------------------------
`include "particulate_air_quality_index_unit_defines.svh"

module paqi_lane #(
	parameter paqi_pkg::band_tab_t BANDS = paqi_pkg::FINE_BANDS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [15:0]         conc,
	input  logic                present,
	output paqi_pkg::lane_res_t res
);

	logic [14:0]                   c;
	logic [paqi_pkg::BAND_W-1:0]   sel;
	logic                          over;
	logic [9:0]                    diff;
	logic [17:0]                   num;
	logic [18:0]                   x;

	logic                          vld_s1, present_s1, over_s1;
	logic [paqi_pkg::BAND_W-1:0]   sel_s1;
	logic [18:0]                   x_s1;

	logic [42:0]                   prod;
	logic                          vld_s2, present_s2, over_s2;
	logic [paqi_pkg::BAND_W-1:0]   sel_s2;
	logic [7:0]                    q_s2;

	logic                          vld_s3, present_s3;
	logic [8:0]                    sub_s3;

	// Stage 1: clamp, first band whose upper limit covers c, numerator
	always_comb begin
		c    = conc[15] ? 15'd0 : conc[14:0];
		sel  = '0;
		over = c > 15'(BANDS[paqi_pkg::BAND_COUNT-1].c_hi);
		for (int k = paqi_pkg::BAND_COUNT - 1; k >= 0; k--) begin
			if (c <= 15'(BANDS[k].c_hi)) begin
				sel = paqi_pkg::BAND_W'(k);
			end
		end
		diff = 10'(c - 15'(BANDS[sel].c_lo));
		num  = {10'd0, BANDS[sel].span} * {8'd0, diff};
		// round half up: (2*num + den) / (2*den)
		x    = {num, 1'b0} + {9'd0, BANDS[sel].den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		present_s1 <= present;
		over_s1    <= over;
		sel_s1     <= sel;
		x_s1       <= x;
	end

	// Stage 2: divide by the band's constant through its reciprocal
	assign prod = {24'd0, x_s1} * {19'd0, BANDS[sel_s1].recip};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		present_s2 <= present_s1;
		over_s2    <= over_s1;
		sel_s2     <= sel_s1;
		q_s2       <= prod[paqi_pkg::RECIP_SHIFT+7:paqi_pkg::RECIP_SHIFT];
	end

	// Stage 3: add band base, saturate above the top band
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		present_s3 <= present_s2;
		sub_s3     <= over_s2 ? paqi_pkg::AQI_TOP : BANDS[sel_s2].i_lo + {1'b0, q_s2};
	end

	assign res = '{vld: vld_s3, present: present_s3, sub: sub_s3};

	`PAQI_IMPLY(a_quot_in_band, clk, arst_n, vld_s2 && !over_s2, q_s2 <= BANDS[sel_s2].span)
	`PAQI_IMPLY(a_sub_range, clk, arst_n, vld_s3, sub_s3 <= paqi_pkg::AQI_TOP)

endmodule

// ===== rtl/core/paqi_merge.sv =====
// ----------------------------------------------------------------------------
// paqi_merge
// Combines the two lane sub-indices into the reported index.
// ----------------------------------------------------------------------------
`include "particulate_air_quality_index_unit_defines.svh"

module paqi_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  paqi_pkg::lane_res_t fine,
	input  paqi_pkg::lane_res_t coarse,
	output paqi_pkg::out_t      result,
	output logic                done
);

	logic [8:0] fine_sub, coarse_sub;
	logic       done_q;
	paqi_pkg::out_t result_q;

	assign fine_sub   = fine.present ? fine.sub : 9'd0;
	assign coarse_sub = coarse.present ? coarse.sub : 9'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fine.vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.aqi       <= (coarse_sub > fine_sub) ? coarse_sub : fine_sub;
		result_q.aqi_valid <= fine.present | coarse.present;
	end

	assign result = result_q;
	assign done   = done_q;

	`PAQI_IMPLY(a_lanes_aligned, clk, arst_n, 1'b1, fine.vld == coarse.vld)

endmodule

// ===== rtl/core/particulate_air_quality_index_unit.sv =====
// ----------------------------------------------------------------------------
// particulate_air_quality_index_unit
// PM2.5 / PM10 piecewise-linear air quality index, two lanes and a merge.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is always low, so a reading may be issued every cycle.
//   Result channel: done is high for exactly one cycle and result is valid
//   in that cycle; the receiver must take it then, it cannot stall the unit.
// Pipeline: band select, reciprocal multiply, base add, then the merge register
//   that drives done and result.
// Throughput: one transaction per cycle; each lane carries one multiplier in
//   each of its first and second stages.
// Reset: arst_n clears all stage valid flags; transactions in flight are
//   dropped and done stays low until new work comes through.
// aqi is 0 with aqi_valid low when neither reading is present.
// ----------------------------------------------------------------------------
`include "particulate_air_quality_index_unit_defines.svh"

module particulate_air_quality_index_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  paqi_pkg::in_t  cmd,
	output paqi_pkg::out_t result,
	output logic           done
);

	logic                accept;
	paqi_pkg::lane_res_t fine_res, coarse_res;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	paqi_lane #(.BANDS(paqi_pkg::FINE_BANDS)) u_fine (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.conc    (cmd.pm25_tenths),
		.present (cmd.pm25_present),
		.res     (fine_res)
	);

	paqi_lane #(.BANDS(paqi_pkg::COARSE_BANDS)) u_coarse (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.conc    (cmd.pm10_whole),
		.present (cmd.pm10_present),
		.res     (coarse_res)
	);

	paqi_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.fine   (fine_res),
		.coarse (coarse_res),
		.result (result),
		.done   (done)
	);

	`PAQI_CHECK(a_latency, clk, arst_n, accept |-> ##4 done)

endmodule

// ===== tb/particulate_air_quality_index_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particulate_air_quality_index_unit_tb
// Drives PM2.5 / PM10 readings into the AQI unit and checks each index that
// comes back against a band-by-band integer interpolation computed here.
// ----------------------------------------------------------------------------
module particulate_air_quality_index_unit_tb;

	localparam int RANDOM_READINGS = 1450;
	localparam int QUIET_LIMIT     = 1000;
	localparam int PM25_TOP        = 3254;
	localparam int PM10_TOP        = 604;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	paqi_pkg::in_t  cmd;
	paqi_pkg::out_t result;
	logic done;

	paqi_pkg::in_t  reading_q[$];
	paqi_pkg::out_t aqi_expect_q[$];
	logic took_item;
	int   sent_cnt;
	int   drain_mark_a;
	int   drain_mark_b;
	int   mismatch_cnt;
	int   quiet_cycles;

	particulate_air_quality_index_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.result (result),
		.done   (done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sub-index of one pollutant: first band whose upper limit is not below
	// the clamped value, interpolated with half-up rounding.
	function automatic int pollutant_sub_index(input logic signed [15:0] raw,
		input bit coarse);
		int c;
		int clo;
		int chi;
		int ilo;
		int ihi;
		int num;
		int den;
		int idx;
		bit found;
		c = (raw < 0) ? 0 : int'(raw);
		idx = 500;
		found = 1'b0;
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: begin
					clo = 0;                    chi = coarse ? 54 : 90;
					ilo = 0;                    ihi = 50;
				end
				1: begin
					clo = coarse ? 55 : 91;     chi = coarse ? 154 : 354;
					ilo = 51;                   ihi = 100;
				end
				2: begin
					clo = coarse ? 155 : 355;   chi = coarse ? 254 : 554;
					ilo = 101;                  ihi = 150;
				end
				3: begin
					clo = coarse ? 255 : 555;   chi = coarse ? 354 : 1254;
					ilo = 151;                  ihi = 200;
				end
				4: begin
					clo = coarse ? 355 : 1255;  chi = coarse ? 424 : 2254;
					ilo = 201;                  ihi = 300;
				end
				default: begin
					clo = coarse ? 425 : 2255;  chi = coarse ? 604 : 3254;
					ilo = 301;                  ihi = 500;
				end
			endcase
			if (!found && c <= chi) begin
				num = (ihi - ilo) * (c - clo);
				den = chi - clo;
				idx = ilo + (2 * num + den) / (2 * den);
				found = 1'b1;
			end
		end
		return idx;
	endfunction

	function automatic paqi_pkg::out_t predict_aqi(input paqi_pkg::in_t rd);
		paqi_pkg::out_t o;
		int best;
		int other;
		best = 0;
		if (rd.pm25_present)
			best = pollutant_sub_index(rd.pm25_tenths, 1'b0);
		if (rd.pm10_present) begin
			other = pollutant_sub_index(rd.pm10_whole, 1'b1);
			if (other > best)
				best = other;
		end
		o.aqi = best[8:0];
		o.aqi_valid = rd.pm25_present | rd.pm10_present;
		return o;
	endfunction

	function automatic paqi_pkg::in_t make_reading(input int p25, input bit f25,
		input int p10, input bit f10);
		paqi_pkg::in_t rd;
		rd.pm25_tenths  = p25[15:0];
		rd.pm25_present = f25;
		rd.pm10_whole   = p10[15:0];
		rd.pm10_present = f10;
		return rd;
	endfunction

	// Mostly in the band range, with some negatives, overshoots and raw 16-bit noise.
	function automatic int pick_conc(input int top);
		int sel;
		int v;
		sel = $urandom_range(99);
		if (sel < 10)
			v = int'($urandom_range(65535)) - 32768;
		else if (sel < 20)
			v = -int'($urandom_range(300, 1));
		else if (sel < 30)
			v = top + int'($urandom_range(2000, 1));
		else
			v = int'($urandom_range(top, 0));
		return v;
	endfunction

	// Driver: one new transaction per accepted one, with random gaps.
	always @(negedge clk) begin : drive_readings
		logic          go;
		paqi_pkg::in_t nxt;
		bit            idle;
		bit            hold;
		if (arst_n) begin
			go = start && !took_item;
			nxt = cmd;
			if (!go) begin
				idle = (sent_cnt < 600 || sent_cnt >= 900) && ($urandom_range(99) < 15);
				hold = (sent_cnt == drain_mark_a || sent_cnt == drain_mark_b)
					&& aqi_expect_q.size() != 0;
				if (reading_q.size() != 0 && !idle && !hold) begin
					nxt = reading_q.pop_front();
					go = 1'b1;
					sent_cnt++;
				end
			end
			start <= go;
			cmd <= nxt;
		end
	end

	// Monitor: compare each result with the oldest prediction, then record
	// any transaction taken at this edge.
	always @(posedge clk) begin : check_results
		paqi_pkg::out_t want;
		if (arst_n) begin
			took_item <= start && !busy;
			if (done) begin
				if (aqi_expect_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: unexpected result, expected none, got aqi %0d valid %0b",
						$time, result.aqi, result.aqi_valid);
				end else begin
					want = aqi_expect_q.pop_front();
					if (result.aqi !== want.aqi) begin
						mismatch_cnt++;
						$display("%0t: aqi mismatch, expected %0d, got %0d",
							$time, want.aqi, result.aqi);
					end
					if (result.aqi_valid !== want.aqi_valid) begin
						mismatch_cnt++;
						$display("%0t: aqi_valid mismatch, expected %0b, got %0b",
							$time, want.aqi_valid, result.aqi_valid);
					end
				end
			end
			if (start && !busy)
				aqi_expect_q.push_back(predict_aqi(cmd));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("particulate_air_quality_index_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		bit f25;
		bit f10;
		int sel;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		took_item = 1'b0;
		sent_cnt = 0;
		mismatch_cnt = 0;
		quiet_cycles = 0;

		// band edges, clamping, overshoot and presence combinations
		reading_q.push_back(make_reading(0, 1'b0, 0, 1'b0));
		reading_q.push_back(make_reading(0, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(90, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(91, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(354, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(355, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(3254, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(3255, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(-1, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(-32768, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(32767, 1'b1, 0, 1'b0));
		reading_q.push_back(make_reading(0, 1'b0, 54, 1'b1));
		reading_q.push_back(make_reading(0, 1'b0, 55, 1'b1));
		reading_q.push_back(make_reading(0, 1'b0, 604, 1'b1));
		reading_q.push_back(make_reading(0, 1'b0, 605, 1'b1));
		reading_q.push_back(make_reading(0, 1'b0, -32768, 1'b1));
		reading_q.push_back(make_reading(0, 1'b0, 32767, 1'b1));
		reading_q.push_back(make_reading(45, 1'b1, 300, 1'b1));
		reading_q.push_back(make_reading(2000, 1'b1, 10, 1'b1));
		reading_q.push_back(make_reading(32767, 1'b0, -1, 1'b0));
		reading_q.push_back(make_reading(1254, 1'b1, 424, 1'b1));
		reading_q.push_back(make_reading(-5, 1'b0, 0, 1'b1));
		drain_mark_a = reading_q.size();
		drain_mark_b = drain_mark_a + 700;

		for (int n = 0; n < RANDOM_READINGS; n++) begin
			sel = $urandom_range(99);
			f25 = (sel < 75);
			f10 = (sel < 60) || (sel >= 75 && sel < 90);
			reading_q.push_back(make_reading(pick_conc(PM25_TOP), f25,
				pick_conc(PM10_TOP), f10));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (reading_q.size() != 0 || start || aqi_expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("particulate_air_quality_index_unit test passed");
		else
			$display("particulate_air_quality_index_unit test failed");
		$finish;
	end

endmodule
